[hw/rtl/qimu_pkg.sv]
// Shared types, register indexes, sensor codes and Jacobian tables for the
// quaternion IMU measurement model. No dependencies.
`default_nettype none

package qimu_pkg;

  localparam int unsigned DataW = 48;   // Q31.16 values
  localparam int unsigned QuatW = 16;   // Q2.14 quaternion parts
  localparam int unsigned CfgIdxW = 2;

  // sensor type codes on the mode input
  typedef enum logic [1:0] {
    MODE_ACCEL = 2'd0,
    MODE_GYRO  = 2'd1,
    MODE_MAG   = 2'd2
  } mode_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_GRAVITY = 2'd0,
    REG_REF_X   = 2'd1,
    REG_REF_Y   = 2'd2,
    REG_REF_Z   = 2'd3
  } reg_e;

  localparam logic signed [DataW-1:0] GravityReset = 48'sd642908;
  localparam logic signed [DataW-1:0] OneQ16 = 48'sd65536;

  // Jacobian factor per [row][quat column][field component]; row 3 unused
  localparam logic signed [3:0] JFAC [4][4][3] = '{
    '{'{4'sd4, 4'sd2, -4'sd2}, '{4'sd4, 4'sd2, 4'sd2},
      '{4'sd0, 4'sd2, -4'sd2}, '{4'sd0, 4'sd2, 4'sd2}},
    '{'{-4'sd2, 4'sd4, 4'sd2}, '{4'sd2, 4'sd0, 4'sd2},
      '{4'sd2, 4'sd4, 4'sd2}, '{-4'sd2, 4'sd0, 4'sd2}},
    '{'{4'sd2, -4'sd2, 4'sd4}, '{4'sd2, -4'sd2, 4'sd0},
      '{4'sd2, 4'sd2, 4'sd0}, '{4'sd2, 4'sd2, 4'sd4}},
    '{'{4'sd0, 4'sd0, 4'sd0}, '{4'sd0, 4'sd0, 4'sd0},
      '{4'sd0, 4'sd0, 4'sd0}, '{4'sd0, 4'sd0, 4'sd0}}
  };

  // quaternion part that each factor scales (0 w, 1 x, 2 y, 3 z)
  localparam logic [1:0] JIDX [4][4][3] = '{
    '{'{2'd0, 2'd3, 2'd2}, '{2'd1, 2'd2, 2'd3}, '{2'd0, 2'd1, 2'd0}, '{2'd0, 2'd0, 2'd1}},
    '{'{2'd3, 2'd0, 2'd1}, '{2'd2, 2'd0, 2'd0}, '{2'd1, 2'd2, 2'd3}, '{2'd0, 2'd0, 2'd2}},
    '{'{2'd2, 2'd1, 2'd0}, '{2'd3, 2'd0, 2'd0}, '{2'd0, 2'd3, 2'd0}, '{2'd1, 2'd2, 2'd3}},
    '{'{2'd0, 2'd0, 2'd0}, '{2'd0, 2'd0, 2'd0}, '{2'd0, 2'd0, 2'd0}, '{2'd0, 2'd0, 2'd0}}
  };

  // clamp to the signed 48-bit range
  function automatic logic signed [DataW-1:0] sat48(input logic signed [59:0] v);
    logic signed [DataW-1:0] r;
    if (v > 60'sh0007FFFFFFFFFFF) begin
      r = 48'sh7FFFFFFFFFFF;
    end else if (v < -60'sh000800000000000) begin
      r = -48'sh800000000000;
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/quat_imu_measurement_model_core.sv]
// Quaternion IMU measurement model: innovation and Jacobian rows per reading.
// Depends on qimu_pkg.
`default_nettype none

// Rows: row 0 leaves the row pipeline first and rows 1 and 2 follow, one
//   row per cycle.
// Requests: the row sequencer takes a new request as it issues row 2 and feeds
//   the five-stage row pipeline one row per cycle; mode 3 is taken and dropped.
// Reset: asynchronous, active low; clears control state and loads the
//   gravity register with 9.81 and the reference field with zero.
module quat_imu_measurement_model_core (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start,
  output logic                              busy,
  input  wire  [1:0]                        mode_i,
  input  wire  signed [qimu_pkg::QuatW-1:0] quat_w_i,
  input  wire  signed [qimu_pkg::QuatW-1:0] quat_x_i,
  input  wire  signed [qimu_pkg::QuatW-1:0] quat_y_i,
  input  wire  signed [qimu_pkg::QuatW-1:0] quat_z_i,
  input  wire  signed [qimu_pkg::DataW-1:0] rate_x_i,
  input  wire  signed [qimu_pkg::DataW-1:0] rate_y_i,
  input  wire  signed [qimu_pkg::DataW-1:0] rate_z_i,
  input  wire  signed [qimu_pkg::DataW-1:0] meas_x_i,
  input  wire  signed [qimu_pkg::DataW-1:0] meas_y_i,
  input  wire  signed [qimu_pkg::DataW-1:0] meas_z_i,
  input  wire                               cfg_we_i,
  input  wire  [qimu_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire  [qimu_pkg::DataW-1:0]        cfg_data_i,
  output logic                              valid_o,
  output logic [1:0]                        row_o,
  output logic signed [qimu_pkg::DataW-1:0] innovation_o,
  output logic signed [qimu_pkg::DataW-1:0] d_qw_o,
  output logic signed [qimu_pkg::DataW-1:0] d_qx_o,
  output logic signed [qimu_pkg::DataW-1:0] d_qy_o,
  output logic signed [qimu_pkg::DataW-1:0] d_qz_o,
  output logic signed [qimu_pkg::DataW-1:0] d_rate_x_o,
  output logic signed [qimu_pkg::DataW-1:0] d_rate_y_o,
  output logic signed [qimu_pkg::DataW-1:0] d_rate_z_o,
  output logic                              last_o
);
  import qimu_pkg::*;

  // ---------------- configuration registers ----------------
  logic signed [DataW-1:0] gravity_q, ref_x_q, ref_y_q, ref_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q <= GravityReset;
      ref_x_q   <= '0;
      ref_y_q   <= '0;
      ref_z_q   <= '0;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_GRAVITY: gravity_q <= cfg_data_i;
        REG_REF_X:   ref_x_q   <= cfg_data_i;
        REG_REF_Y:   ref_y_q   <= cfg_data_i;
        REG_REF_Z:   ref_z_q   <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // ---------------- request capture and row sequencer ----------------
  logic                    accept;
  logic                    act_q;
  logic [1:0]              cnt_q;
  logic [1:0]              hmode_q;
  logic signed [QuatW-1:0] hq_q [4];
  logic signed [DataW-1:0] hrate_q [3];
  logic signed [DataW-1:0] hmeas_q [3];

  assign busy   = act_q && (cnt_q != 2'd2);
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      cnt_q <= 2'd0;
    end else if (accept) begin
      act_q <= (mode_i == MODE_ACCEL) || (mode_i == MODE_GYRO) || (mode_i == MODE_MAG);
      cnt_q <= 2'd0;
    end else if (act_q) begin
      if (cnt_q == 2'd2) begin
        act_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hmode_q    <= mode_i;
      hq_q[0]    <= quat_w_i;
      hq_q[1]    <= quat_x_i;
      hq_q[2]    <= quat_y_i;
      hq_q[3]    <= quat_z_i;
      hrate_q[0] <= rate_x_i;
      hrate_q[1] <= rate_y_i;
      hrate_q[2] <= rate_z_i;
      hmeas_q[0] <= meas_x_i;
      hmeas_q[1] <= meas_y_i;
      hmeas_q[2] <= meas_z_i;
    end
  end

  // ---------------- stage 1: rotation row, field vector, Jacobian factors ----------------
  logic signed [31:0] pww, pxx, pyy, pzz, pwx, pwy, pwz, pxy, pxz, pyz;
  logic signed [33:0] rot_d [3];
  logic signed [DataW-1:0] fld_d [3];
  logic signed [19:0] coef_d [4][3];

  assign pww = 32'(hq_q[0] * hq_q[0]);
  assign pxx = 32'(hq_q[1] * hq_q[1]);
  assign pyy = 32'(hq_q[2] * hq_q[2]);
  assign pzz = 32'(hq_q[3] * hq_q[3]);
  assign pwx = 32'(hq_q[0] * hq_q[1]);
  assign pwy = 32'(hq_q[0] * hq_q[2]);
  assign pwz = 32'(hq_q[0] * hq_q[3]);
  assign pxy = 32'(hq_q[1] * hq_q[2]);
  assign pxz = 32'(hq_q[1] * hq_q[3]);
  assign pyz = 32'(hq_q[2] * hq_q[3]);

  // row k of the transposed rotation matrix, Q.28
  always_comb begin
    case (cnt_q)
      2'd0: begin
        rot_d[0] = 34'((34'(pww) + 34'(pxx)) <<< 1) - 34'sd268435456;
        rot_d[1] = 34'((34'(pwz) + 34'(pxy)) <<< 1);
        rot_d[2] = 34'((34'(pxz) - 34'(pwy)) <<< 1);
      end
      2'd1: begin
        rot_d[0] = 34'((34'(pxy) - 34'(pwz)) <<< 1);
        rot_d[1] = 34'((34'(pww) + 34'(pyy)) <<< 1) - 34'sd268435456;
        rot_d[2] = 34'((34'(pwx) + 34'(pyz)) <<< 1);
      end
      2'd2: begin
        rot_d[0] = 34'((34'(pwy) + 34'(pxz)) <<< 1);
        rot_d[1] = 34'((34'(pyz) - 34'(pwx)) <<< 1);
        rot_d[2] = 34'((34'(pww) + 34'(pzz)) <<< 1) - 34'sd268435456;
      end
      default: begin
        rot_d[0] = '0;
        rot_d[1] = '0;
        rot_d[2] = '0;
      end
    endcase
  end

  // field vector: gravity on z for the accelerometer, else reference field
  always_comb begin
    if (hmode_q == MODE_ACCEL) begin
      fld_d[0] = '0;
      fld_d[1] = '0;
      fld_d[2] = gravity_q;
    end else begin
      fld_d[0] = ref_x_q;
      fld_d[1] = ref_y_q;
      fld_d[2] = ref_z_q;
    end
  end

  // small factor times the selected quaternion part
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 3; i++) begin
        coef_d[j][i] = 20'(hq_q[JIDX[cnt_q][j][i]] * JFAC[cnt_q][j][i]);
      end
    end
  end

  logic                    v1_q, v2_q, v3_q, v4_q;
  logic [1:0]              row1_q, row2_q, row3_q, row4_q;
  logic                    gyro1_q, gyro2_q, gyro3_q, gyro4_q;
  logic signed [DataW-1:0] meas1_q, meas2_q, meas3_q;
  logic signed [DataW-1:0] rate1_q, rate2_q, rate3_q;
  logic signed [33:0]      rot1_q [3];
  logic signed [DataW-1:0] fld1_q [3];
  logic signed [19:0]      coef1_q [4][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= act_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    row1_q  <= cnt_q;
    gyro1_q <= (hmode_q == MODE_GYRO);
    meas1_q <= hmeas_q[cnt_q];
    rate1_q <= hrate_q[cnt_q];
    rot1_q  <= rot_d;
    fld1_q  <= fld_d;
    coef1_q <= coef_d;
  end

  // ---------------- stage 2: partial products on 24-bit field halves ----------------
  logic signed [23:0] fh [3];
  logic signed [24:0] fl [3];
  logic signed [57:0] rh2_q [3];
  logic signed [58:0] rl2_q [3];
  logic signed [43:0] jh2_q [4][3];
  logic signed [44:0] jl2_q [4][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fh[i] = fld1_q[i][47:24];
      fl[i] = $signed({1'b0, fld1_q[i][23:0]});
    end
  end

  always_ff @(posedge clk_i) begin
    row2_q  <= row1_q;
    gyro2_q <= gyro1_q;
    meas2_q <= meas1_q;
    rate2_q <= rate1_q;
    for (int i = 0; i < 3; i++) begin
      rh2_q[i] <= 58'(rot1_q[i] * fh[i]);
      rl2_q[i] <= 59'(rot1_q[i] * fl[i]);
      for (int j = 0; j < 4; j++) begin
        jh2_q[j][i] <= 44'(coef1_q[j][i] * fh[i]);
        jl2_q[j][i] <= 45'(coef1_q[j][i] * fl[i]);
      end
    end
  end

  // ---------------- stage 3: join halves into full products ----------------
  logic signed [81:0] rp3_q [3];
  logic signed [67:0] jp3_q [4][3];

  always_ff @(posedge clk_i) begin
    row3_q  <= row2_q;
    gyro3_q <= gyro2_q;
    meas3_q <= meas2_q;
    rate3_q <= rate2_q;
    for (int i = 0; i < 3; i++) begin
      rp3_q[i] <= (82'(rh2_q[i]) <<< 24) + 82'(rl2_q[i]);
      for (int j = 0; j < 4; j++) begin
        jp3_q[j][i] <= (68'(jh2_q[j][i]) <<< 24) + 68'(jl2_q[j][i]);
      end
    end
  end

  // ---------------- stage 4: sums with round half up ----------------
  logic signed [87:0] inn_sum;
  logic signed [69:0] jac_sum [4];
  logic signed [59:0] inn4_q;
  logic signed [55:0] jac4_q [4];
  logic signed [48:0] gdiff4_q;

  assign inn_sum = (88'(meas3_q) <<< 28) - 88'(rp3_q[0]) - 88'(rp3_q[1])
                 - 88'(rp3_q[2]) + 88'sd134217728;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      jac_sum[j] = 70'(jp3_q[j][0]) + 70'(jp3_q[j][1]) + 70'(jp3_q[j][2]) + 70'sd8192;
    end
  end

  always_ff @(posedge clk_i) begin
    row4_q   <= row3_q;
    gyro4_q  <= gyro3_q;
    inn4_q   <= inn_sum[87:28];
    gdiff4_q <= 49'(meas3_q) - 49'(rate3_q);
    for (int j = 0; j < 4; j++) begin
      jac4_q[j] <= jac_sum[j][69:14];
    end
  end

  // ---------------- stage 5: saturate and register the row ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
      last_o  <= 1'b0;
      row_o   <= 2'd0;
    end else begin
      valid_o <= v4_q;
      last_o  <= v4_q && (row4_q == 2'd2);
      row_o   <= row4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (gyro4_q) begin
      innovation_o <= sat48(60'(gdiff4_q));
      d_qw_o       <= '0;
      d_qx_o       <= '0;
      d_qy_o       <= '0;
      d_qz_o       <= '0;
      d_rate_x_o   <= (row4_q == 2'd0) ? OneQ16 : '0;
      d_rate_y_o   <= (row4_q == 2'd1) ? OneQ16 : '0;
      d_rate_z_o   <= (row4_q == 2'd2) ? OneQ16 : '0;
    end else begin
      innovation_o <= sat48(inn4_q);
      d_qw_o       <= sat48(60'(jac4_q[0]));
      d_qx_o       <= sat48(60'(jac4_q[1]));
      d_qy_o       <= sat48(60'(jac4_q[2]));
      d_qz_o       <= sat48(60'(jac4_q[3]));
      d_rate_x_o   <= '0;
      d_rate_y_o   <= '0;
      d_rate_z_o   <= '0;
    end
  end

  // ---------------- assertions ----------------
  // a taken mode 3 request leaves the row sequencer idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (mode_i != MODE_GYRO) && (mode_i != MODE_ACCEL) && (mode_i != MODE_MAG)
    |=> !act_q || (cnt_q == 2'd2) || $past(act_q))
    else $error("dropped request changed sequencer state");

  a_seq_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (mode_i == MODE_GYRO) |=> act_q && (cnt_q == 2'd0))
    else $error("sequencer did not start");

  // rows leave in order on consecutive cycles
  a_row1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (row_o == 2'd1) |-> $past(valid_o) && ($past(row_o) == 2'd0))
    else $error("row 1 not after row 0");

  a_row2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (row_o == 2'd2) |-> $past(valid_o) && ($past(row_o) == 2'd1) && last_o)
    else $error("row 2 out of order or not marked last");

  a_no_idle_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && !act_q && !v1_q && !v2_q && !v3_q && !v4_q |=> !valid_o)
    else $error("row produced without request");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for quat_imu_measurement_model_core: random and
// directed sensor requests checked row by row. Depends on qimu_pkg and the core.
`timescale 1ns / 1ps

module tb_top;
  import qimu_pkg::*;

  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned DrainCycles = 12;

  typedef struct {
    logic [1:0] mode;
    logic signed [15:0] qw, qx, qy, qz;
    logic signed [47:0] rx, ry, rz, mx, my, mz;
    logic is_cfg;       // register write marker, applied when the block is idle
    logic [1:0] cfg_idx;
    logic [47:0] cfg_val;
    logic hold;         // wait until every expected row has come
  } imu_req_t;

  typedef struct {
    logic [1:0] row;
    logic signed [47:0] innov;
    logic signed [47:0] jac [7];
    logic last;
  } imu_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] mode_i = '0;
  logic signed [15:0] quat_w_i = '0, quat_x_i = '0, quat_y_i = '0, quat_z_i = '0;
  logic signed [47:0] rate_x_i = '0, rate_y_i = '0, rate_z_i = '0;
  logic signed [47:0] meas_x_i = '0, meas_y_i = '0, meas_z_i = '0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [47:0] cfg_data_i = '0;
  logic valid_o, last_o;
  logic [1:0] row_o;
  logic signed [47:0] innovation_o, d_qw_o, d_qx_o, d_qy_o, d_qz_o;
  logic signed [47:0] d_rate_x_o, d_rate_y_o, d_rate_z_o;

  quat_imu_measurement_model_core dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  imu_req_t pending_q [$];
  imu_row_t expected_rows [$];
  logic signed [47:0] gravity_r = GravityReset;
  logic signed [47:0] field_r [3] = '{default: '0};
  int unsigned idle_pct = 0;
  int unsigned fail_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned drain_cnt = 0;

  // Round a Q.44-scaled sum back to Q31.16 and clamp to 48 bits
  function automatic logic signed [47:0] round_sat(input logic signed [127:0] s);
    logic signed [127:0] r;
    r = (s + (128'sd1 <<< 27)) >>> 28;
    if (r > 128'sh7FFFFFFFFFFF) return 48'sh7FFFFFFFFFFF;
    if (r < -128'sh800000000000) return 48'sh800000000000;
    return r[47:0];
  endfunction

  // Expected rows for one sensor request
  task automatic predict_rows(input imu_req_t rq);
    logic signed [63:0] q [4];
    logic signed [63:0] rot [3][3];
    logic signed [127:0] fld [3], meas [3], rate [3], acc;
    imu_row_t rw;
    q[0] = rq.qw; q[1] = rq.qx; q[2] = rq.qy; q[3] = rq.qz;
    meas[0] = rq.mx; meas[1] = rq.my; meas[2] = rq.mz;
    rate[0] = rq.rx; rate[1] = rq.ry; rate[2] = rq.rz;
    if (rq.mode == MODE_ACCEL) begin
      fld[0] = 0; fld[1] = 0; fld[2] = gravity_r;
    end else begin
      for (int i = 0; i < 3; i++) fld[i] = field_r[i];
    end
    rot[0][0] = 2 * (q[0] * q[0] + q[1] * q[1]) - (64'sd1 <<< 28);
    rot[0][1] = 2 * (q[0] * q[3] + q[1] * q[2]);
    rot[0][2] = 2 * (q[1] * q[3] - q[0] * q[2]);
    rot[1][0] = 2 * (q[1] * q[2] - q[0] * q[3]);
    rot[1][1] = 2 * (q[0] * q[0] + q[2] * q[2]) - (64'sd1 <<< 28);
    rot[1][2] = 2 * (q[0] * q[1] + q[2] * q[3]);
    rot[2][0] = 2 * (q[0] * q[2] + q[1] * q[3]);
    rot[2][1] = 2 * (q[2] * q[3] - q[0] * q[1]);
    rot[2][2] = 2 * (q[0] * q[0] + q[3] * q[3]) - (64'sd1 <<< 28);
    for (int k = 0; k < 3; k++) begin
      rw.row = k[1:0];
      rw.last = (k == 2);
      for (int j = 0; j < 7; j++) rw.jac[j] = '0;
      if (rq.mode == MODE_GYRO) begin
        rw.innov = round_sat((meas[k] - rate[k]) <<< 28);
        rw.jac[4 + k] = OneQ16;
      end else begin
        acc = meas[k] <<< 28;
        for (int i = 0; i < 3; i++) acc -= rot[k][i] * fld[i];
        rw.innov = round_sat(acc);
        for (int j = 0; j < 4; j++) begin
          acc = 0;
          for (int i = 0; i < 3; i++)
            acc += 128'(JFAC[k][j][i]) * q[JIDX[k][j][i]] * 16384 * fld[i];
          rw.jac[j] = round_sat(acc);
        end
      end
      expected_rows.push_back(rw);
    end
  endtask

  function automatic logic signed [47:0] rand48();
    case ($urandom_range(0, 5))
      0: return 48'sh7FFFFFFFFFFF;
      1: return 48'sh800000000000;
      2: return $signed(48'($urandom_range(0, 1 << 22))) - 48'sd2097152;
      default: return 48'({$urandom(), $urandom()});
    endcase
  endfunction

  function automatic logic signed [15:0] rand_quat();
    case ($urandom_range(0, 4))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic imu_req_t make_req(input logic [1:0] md);
    imu_req_t r;
    r = '{default: '0};
    r.mode = md;
    r.qw = rand_quat(); r.qx = rand_quat(); r.qy = rand_quat(); r.qz = rand_quat();
    r.rx = rand48(); r.ry = rand48(); r.rz = rand48();
    r.mx = rand48(); r.my = rand48(); r.mz = rand48();
    return r;
  endfunction

  function automatic imu_req_t cfg_req(input reg_e idx, input logic [47:0] val);
    imu_req_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.cfg_idx = idx;
    r.cfg_val = val;
    return r;
  endfunction

  // Stimulus plan
  initial begin
    imu_req_t r;
    logic [1:0] md;
    // directed: identity and extreme quaternions in every mode, plus mode 3
    for (int m = 0; m < 4; m++) begin
      r = make_req(m[1:0]);
      r.qw = 16'sd16384; r.qx = '0; r.qy = '0; r.qz = '0;
      pending_q.push_back(r);
      r = make_req(m[1:0]);
      r.qw = 16'sh8000; r.qx = 16'sh8000; r.qy = 16'sh8000; r.qz = 16'sh8000;
      r.mx = 48'sh7FFFFFFFFFFF; r.my = 48'sh800000000000; r.mz = '0;
      r.rx = 48'sh800000000000; r.ry = 48'sh7FFFFFFFFFFF; r.rz = '0;
      pending_q.push_back(r);
    end
    pending_q.push_back(cfg_req(REG_REF_X, 48'h7FFFFFFFFFFF));
    pending_q.push_back(cfg_req(REG_REF_Y, 48'h800000000000));
    pending_q.push_back(cfg_req(REG_REF_Z, 48'd1234567));
    pending_q.push_back(cfg_req(REG_GRAVITY, 48'h800000000000));
    for (int m = 0; m < 3; m++) begin
      r = make_req(m[1:0]);
      r.qw = 16'sh7FFF; r.qx = 16'sh7FFF; r.qy = 16'sh8000; r.qz = 16'sh7FFF;
      pending_q.push_back(r);
    end
    r = make_req(MODE_ACCEL);
    r.hold = 1'b1;
    pending_q.push_back(r);
    // random phases, each under new register settings
    for (int ph = 0; ph < 8; ph++) begin
      pending_q.push_back(cfg_req(REG_GRAVITY, ph == 1 ? 48'h7FFFFFFFFFFF : rand48()));
      pending_q.push_back(cfg_req(REG_REF_X, rand48()));
      pending_q.push_back(cfg_req(REG_REF_Y, rand48()));
      pending_q.push_back(cfg_req(REG_REF_Z, ph == 2 ? 48'h800000000000 : rand48()));
      for (int n = 0; n < 55; n++) begin
        md = $urandom_range(0, 15) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
        r = make_req(md);
        if (n == 30) r.hold = 1'b1;
        pending_q.push_back(r);
      end
    end
  end

  // Idling profile steps through idle shares of 0, 78, 0 and 16 percent
  int unsigned cyc = 0;
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    case ((cyc / 150) % 4)
      0: idle_pct <= 0;
      1: idle_pct <= 78;
      2: idle_pct <= 0;
      default: idle_pct <= 16;
    endcase
  end

  // Request driver: register writes wait for an empty pipeline
  always @(posedge clk_i) begin
    if (rst_ni) begin
      imu_req_t r;
      logic go;
      logic we;
      we = 1'b0;
      go = 1'b1;
      if (start && !busy) begin
        void'(pending_q.pop_front());
      end
      if (start && busy) begin
        go = 1'b0; // still holding the current request
      end else if (pending_q.size() > 0) begin
        r = pending_q[0];
        if (r.is_cfg || r.hold) begin
          if (expected_rows.size() != 0 || start || drain_cnt < DrainCycles) go = 1'b0;
        end
        if (go && $urandom_range(1, 100) <= idle_pct) go = 1'b0;
        if (go && r.is_cfg) begin
          we = 1'b1;
          cfg_idx_i <= r.cfg_idx;
          cfg_data_i <= r.cfg_val;
          case (reg_e'(r.cfg_idx))
            REG_GRAVITY: gravity_r <= r.cfg_val;
            REG_REF_X:   field_r[0] <= r.cfg_val;
            REG_REF_Y:   field_r[1] <= r.cfg_val;
            default:     field_r[2] <= r.cfg_val;
          endcase
          void'(pending_q.pop_front());
          start <= 1'b0;
        end else if (go) begin
          start <= 1'b1;
          mode_i <= r.mode;
          quat_w_i <= r.qw; quat_x_i <= r.qx; quat_y_i <= r.qy; quat_z_i <= r.qz;
          rate_x_i <= r.rx; rate_y_i <= r.ry; rate_z_i <= r.rz;
          meas_x_i <= r.mx; meas_y_i <= r.my; meas_z_i <= r.mz;
        end else begin
          start <= 1'b0;
        end
      end else begin
        start <= 1'b0;
      end
      cfg_we_i <= we;
    end
  end

  // Predictor hook: every accepted request that is not mode 3 yields three rows
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy && mode_i != 2'd3) begin
      imu_req_t r;
      r = '{default: '0};
      r.mode = mode_i;
      r.qw = quat_w_i; r.qx = quat_x_i; r.qy = quat_y_i; r.qz = quat_z_i;
      r.rx = rate_x_i; r.ry = rate_y_i; r.rz = rate_z_i;
      r.mx = meas_x_i; r.my = meas_y_i; r.mz = meas_z_i;
      predict_rows(r);
    end
  end

  // Row monitor and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      logic signed [47:0] got [7];
      imu_row_t e;
      got = '{d_qw_o, d_qx_o, d_qy_o, d_qz_o, d_rate_x_o, d_rate_y_o, d_rate_z_o};
      if (valid_o) begin
        if (expected_rows.size() == 0) begin
          $error("unexpected row %0d", row_o);
          fail_cnt++;
        end else begin
          e = expected_rows.pop_front();
          if (row_o !== e.row) begin
            $error("row: expected %0d got %0d", e.row, row_o); fail_cnt++;
          end
          if (innovation_o !== e.innov) begin
            $error("innovation: expected %0d got %0d", e.innov, innovation_o); fail_cnt++;
          end
          for (int j = 0; j < 7; j++)
            if (got[j] !== e.jac[j]) begin
              $error("jacobian col %0d: expected %0d got %0d", j, e.jac[j], got[j]);
              fail_cnt++;
            end
          if (last_o !== e.last) begin
            $error("last: expected %0d got %0d", e.last, last_o); fail_cnt++;
          end
        end
      end
      drain_cnt <= (valid_o || (start && !busy)) ? 0 : drain_cnt + 1;
      idle_cycles <= (valid_o || (start && !busy) || cfg_we_i) ? 0 : idle_cycles + 1;
    end
  end

  // Reset, end of run and watchdog
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (idle_cycles >= IdleLimit) begin
        $display("FAILED: results differ");
        $finish;
      end
      if (pending_q.size() == 0 && !start && expected_rows.size() == 0
          && drain_cnt >= DrainCycles) begin
        if (fail_cnt == 0) begin
          $display("PASSED: all results match");
        end else begin
          $display("FAILED: results differ");
        end
        $finish;
      end
    end
  end

endmodule
